FILE: src/swdh_pkg.sv
// ----------------------------------------------------------------------------
// SWD host package
// Shared widths, command codes, sequencer phases and the per-tick result type.
// ----------------------------------------------------------------------------
package swdh_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned FUNC_W     = 2;
	localparam int unsigned ADDR_W     = 2;
	localparam int unsigned ACK_W      = 3;
	localparam int unsigned RETRY_W    = 4;
	localparam int unsigned BITCNT_W   = 7;
	localparam int unsigned LIMIT_W    = BITCNT_W + 1;

	localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd15;

	// Line reset, recovery and field lengths, in bits.
	localparam logic [LIMIT_W-1:0] RESET_ONES         = 8'd64;
	localparam logic [LIMIT_W-1:0] RESET_ZEROS        = 8'd64;
	localparam logic [LIMIT_W-1:0] RECOVERY_IDLE_BITS = 8'd32;
	localparam logic [LIMIT_W-1:0] SWITCH_KEY_BITS    = 8'd16;
	localparam logic [LIMIT_W-1:0] REQ_BITS           = 8'd8;
	localparam logic [LIMIT_W-1:0] ACK_BITS           = 8'd3;
	localparam logic [LIMIT_W-1:0] DATA_BITS          = 8'd32;

	// JTAG-to-SWD switch key, sent LSB first.
	localparam logic [15:0] SWITCH_KEY = 16'hE79E;

	localparam logic [ACK_W-1:0] ACK_OK = 3'b001;

	// Command codes on the func field.
	localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LRST  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_RST_HI1 = 4'd1,
		PH_RST_KEY = 4'd2,
		PH_RST_HI2 = 4'd3,
		PH_RST_LO  = 4'd4,
		PH_REQ     = 4'd5,
		PH_ACK     = 4'd6,
		PH_RDATA   = 4'd7,
		PH_RPAR    = 4'd8,
		PH_WDATA   = 4'd9,
		PH_WPAR    = 4'd10,
		PH_TRAIL   = 4'd11,
		PH_RECOVER = 4'd12
	} phase_t;

	typedef struct packed {
		logic              clock_pulse;
		logic              swdio_out;
		logic              swdio_oe;
		logic              done_res;
		logic              status;
		logic [WORD_W-1:0] read_data;
		logic [ACK_W-1:0]  last_ack;
		logic              busy_res;
	} swdh_result_t;

endpackage

FILE: src/swdh_if.sv
// ----------------------------------------------------------------------------
// SWD host channel interfaces
// Valid/ready channels for commands and per-tick results.
// ----------------------------------------------------------------------------
interface swdh_cmd_if
	import swdh_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic              ap_not_dp;
	logic              read_not_write;
	logic [ADDR_W-1:0] reg_addr;
	logic [WORD_W-1:0] write_data;
	logic              swdio_in;

	modport source (
		output valid, func, ap_not_dp, read_not_write, reg_addr, write_data, swdio_in,
		input  ready
	);
	modport sink (
		input  valid, func, ap_not_dp, read_not_write, reg_addr, write_data, swdio_in,
		output ready
	);
endinterface

interface swdh_rsp_if
	import swdh_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              clock_pulse;
	logic              swdio_out;
	logic              swdio_oe;
	logic              done_res;
	logic              status;
	logic [WORD_W-1:0] read_data;
	logic [ACK_W-1:0]  last_ack;
	logic              busy_res;

	modport source (
		output valid, clock_pulse, swdio_out, swdio_oe, done_res, status, read_data,
		       last_ack, busy_res,
		input  ready
	);
	modport sink (
		input  valid, clock_pulse, swdio_out, swdio_oe, done_res, status, read_data,
		       last_ack, busy_res,
		output ready
	);
endinterface

FILE: src/swdh_seq.sv
// ----------------------------------------------------------------------------
// SWD host pin sequencer
// Protocol state and the combinational result of one command or tick.
// ----------------------------------------------------------------------------
module swdh_seq
	import swdh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [FUNC_W-1:0]  func,
	input  logic               ap_not_dp,
	input  logic               read_not_write,
	input  logic [ADDR_W-1:0]  reg_addr,
	input  logic [WORD_W-1:0]  write_data,
	input  logic               swdio_in,
	input  logic [RETRY_W-1:0] retry_limit,
	output swdh_result_t       res
);

	phase_t               phase_q, phase_d;
	logic [BITCNT_W-1:0]  bit_count_q, bit_count_d;
	logic [WORD_W-1:0]    shift_word_q, shift_word_d;
	logic                 host_drives_q, host_drives_d;
	logic [RETRY_W-1:0]   attempts_q, attempts_d;
	logic [3:0]           latched_req_q, latched_req_d;
	logic                 parity_acc_q, parity_acc_d;
	logic [WORD_W-1:0]    read_word_q, read_word_d;
	logic [ACK_W-1:0]     ack_bits_q, ack_bits_d;

	logic                 tick;
	logic                 need_drive;
	logic                 turn;
	logic [LIMIT_W-1:0]   bit_next;
	logic [LIMIT_W-1:0]   limit;
	logic                 last_bit;
	logic [ACK_W-1:0]     ack_acc;
	logic                 wbit;
	logic [RETRY_W-1:0]   attempts_inc;
	logic                 give_up;
	logic [7:0]           req_byte;

	// Request: start, APnDP, RnW, A[3:2], parity, stop, park.
	always_comb begin
		req_byte = {1'b1, 1'b0, ^latched_req_q, latched_req_q[3:2],
			latched_req_q[1], latched_req_q[0], 1'b1};
	end

	always_comb begin
		case (phase_q)
			PH_RST_HI1, PH_RST_HI2: limit = RESET_ONES;
			PH_RST_KEY:             limit = SWITCH_KEY_BITS;
			PH_RST_LO:              limit = RESET_ZEROS;
			PH_REQ:                 limit = REQ_BITS;
			PH_ACK:                 limit = ACK_BITS;
			PH_RDATA, PH_WDATA:     limit = DATA_BITS;
			PH_RECOVER:             limit = RECOVERY_IDLE_BITS;
			default:                limit = LIMIT_W'(1);
		endcase
	end

	assign tick         = step && (func == FUNC_TICK) && (phase_q != PH_IDLE);
	assign need_drive   = !(phase_q == PH_ACK || phase_q == PH_RDATA || phase_q == PH_RPAR);
	assign turn         = tick && (need_drive != host_drives_q);
	assign bit_next     = {1'b0, bit_count_q} + LIMIT_W'(1);
	assign last_bit     = bit_next >= limit;
	assign ack_acc      = ack_bits_q | (ACK_W'(swdio_in) << bit_count_q[1:0]);
	assign wbit         = shift_word_q[bit_count_q[4:0]];
	assign attempts_inc = attempts_q + RETRY_W'(1);
	assign give_up      = attempts_inc >= retry_limit;

	// Next state
	always_comb begin
		phase_d       = phase_q;
		bit_count_d   = bit_count_q;
		shift_word_d  = shift_word_q;
		host_drives_d = host_drives_q;
		attempts_d    = attempts_q;
		latched_req_d = latched_req_q;
		parity_acc_d  = parity_acc_q;
		read_word_d   = read_word_q;
		ack_bits_d    = ack_bits_q;
		if (step && func == FUNC_START && phase_q == PH_IDLE) begin
			latched_req_d = {reg_addr, read_not_write, ap_not_dp};
			shift_word_d  = write_data;
			attempts_d    = '0;
			bit_count_d   = '0;
			phase_d       = PH_REQ;
		end else if (step && func == FUNC_LRST && phase_q == PH_IDLE) begin
			host_drives_d = 1'b0;
			bit_count_d   = '0;
			phase_d       = PH_RST_HI1;
		end else if (turn) begin
			host_drives_d = need_drive;
		end else if (tick) begin
			bit_count_d = last_bit ? '0 : bit_next[BITCNT_W-1:0];
			unique case (phase_q)
				PH_RST_HI1: if (last_bit) phase_d = PH_RST_KEY;
				PH_RST_KEY: if (last_bit) phase_d = PH_RST_HI2;
				PH_RST_HI2: if (last_bit) phase_d = PH_RST_LO;
				PH_RST_LO:  if (last_bit) phase_d = PH_IDLE;
				PH_REQ: begin
					if (last_bit) begin
						phase_d    = PH_ACK;
						ack_bits_d = '0;
					end
				end
				PH_ACK: begin
					ack_bits_d = ack_acc;
					if (last_bit) begin
						parity_acc_d = 1'b0;
						if (ack_acc != ACK_OK) begin
							phase_d = PH_RECOVER;
						end else if (latched_req_q[1]) begin
							shift_word_d = '0;
							phase_d      = PH_RDATA;
						end else begin
							phase_d = PH_WDATA;
						end
					end
				end
				PH_RDATA: begin
					shift_word_d = shift_word_q | (WORD_W'(swdio_in) << bit_count_q[4:0]);
					parity_acc_d = parity_acc_q ^ swdio_in;
					if (last_bit) phase_d = PH_RPAR;
				end
				PH_RPAR: begin
					bit_count_d = '0;
					if (swdio_in == parity_acc_q) begin
						read_word_d = shift_word_q;
						phase_d     = PH_TRAIL;
					end else begin
						phase_d = PH_RECOVER;
					end
				end
				PH_WDATA: begin
					parity_acc_d = parity_acc_q ^ wbit;
					if (last_bit) phase_d = PH_WPAR;
				end
				PH_WPAR: begin
					bit_count_d = '0;
					phase_d     = PH_TRAIL;
				end
				PH_TRAIL: begin
					bit_count_d = '0;
					phase_d     = PH_IDLE;
				end
				PH_RECOVER: begin
					if (last_bit) begin
						attempts_d = attempts_inc;
						phase_d    = give_up ? PH_IDLE : PH_REQ;
					end
				end
				default: begin
					phase_d     = PH_IDLE;
					bit_count_d = '0;
				end
			endcase
		end
	end

	// Result of this step
	always_comb begin
		logic dbit;
		logic known;
		dbit  = 1'b0;
		known = 1'b1;
		res.done_res = 1'b0;
		res.status   = 1'b0;
		if (tick && !turn) begin
			unique case (phase_q)
				PH_RST_HI1, PH_RST_HI2: dbit = 1'b1;
				PH_RST_KEY: dbit = SWITCH_KEY[bit_count_q[3:0]];
				PH_RST_LO:  res.done_res = last_bit;
				PH_REQ:     dbit = req_byte[bit_count_q[2:0]];
				PH_WDATA:   dbit = wbit;
				PH_WPAR:    dbit = parity_acc_q;
				PH_TRAIL:   res.done_res = 1'b1;
				PH_RECOVER: begin
					res.done_res = last_bit && give_up;
					res.status   = last_bit && give_up;
				end
				PH_ACK, PH_RDATA, PH_RPAR: dbit = 1'b0;
				default: known = 1'b0;
			endcase
		end
		res.clock_pulse = tick && known;
		res.swdio_oe    = turn ? 1'b0 : host_drives_d;
		res.swdio_out   = dbit && !turn && host_drives_d;
		res.read_data   = read_word_d;
		res.last_ack    = ack_bits_d;
		res.busy_res    = phase_d != PH_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_count_q   <= '0;
			shift_word_q  <= '0;
			host_drives_q <= 1'b0;
			attempts_q    <= '0;
			latched_req_q <= '0;
			parity_acc_q  <= 1'b0;
			read_word_q   <= '0;
			ack_bits_q    <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			bit_count_q   <= bit_count_d;
			shift_word_q  <= shift_word_d;
			host_drives_q <= host_drives_d;
			attempts_q    <= attempts_d;
			latched_req_q <= latched_req_d;
			parity_acc_q  <= parity_acc_d;
			read_word_q   <= read_word_d;
			ack_bits_q    <= ack_bits_d;
		end
	end

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE && !step) |=> phase_q == PH_IDLE)
		else $error("sequencer left idle without a command");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.done_res) |=> phase_q == PH_IDLE)
		else $error("command reported done but sequencer still busy");

	a_target_phase_released: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && (phase_q == PH_ACK || phase_q == PH_RDATA || phase_q == PH_RPAR))
		|-> !res.swdio_oe)
		else $error("host drives the pin while the target owns it");

	a_ack_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ACK) |-> bit_count_q < BITCNT_W'(ACK_BITS))
		else $error("acknowledge bit count out of range");

endmodule

FILE: src/swd_host_transfer_engine_core.sv
// ----------------------------------------------------------------------------
// SWD host transfer engine
// Drives the SWD pins one clock period per tick: DP/AP transfers with
// retry and the line reset / switch sequence.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries commands: start a transfer, start a line reset, or a bit tick
//   with the sampled SWDIO level. Every accepted command yields exactly one
//   result on rsp: clock pulse, SWDIO level and enable, done/status, the last
//   read word, the last acknowledge and busy.
//   cfg_we/cfg_wdata write retry_limit (attempts per transfer, 0 acts as 1);
//   write it only while no command is in flight.
//   Result: registered; valid in the cycle after the transfer on cmd.
//   Throughput: one command per cycle while rsp takes results; all protocol
//   work for a command is a single pass of the sequencer logic between the
//   state registers and the result register.
//   Reset: retry_limit = 15, sequencer idle, SWDIO released, read word and
//   acknowledge cleared.
//   Stall: a result not taken on rsp is held in the result register and
//   cmd.ready drops until the result leaves; no command is lost.
// ----------------------------------------------------------------------------
module swd_host_transfer_engine_core
	import swdh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	swdh_cmd_if.sink           cmd,
	swdh_rsp_if.source         rsp,
	input  logic               cfg_we,
	input  logic [RETRY_W-1:0] cfg_wdata
);

	logic [RETRY_W-1:0] retry_limit_q;
	logic               accept;
	swdh_result_t       seq_res;
	swdh_result_t       rsp_s1;
	logic               rsp_valid_s1;

	// Result register frees up when empty or when its transfer completes.
	assign cmd.ready = !rsp_valid_s1 || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			retry_limit_q <= cfg_wdata;
		end
	end

	swdh_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (accept),
		.func           (cmd.func),
		.ap_not_dp      (cmd.ap_not_dp),
		.read_not_write (cmd.read_not_write),
		.reg_addr       (cmd.reg_addr),
		.write_data     (cmd.write_data),
		.swdio_in       (cmd.swdio_in),
		.retry_limit    (retry_limit_q),
		.res            (seq_res)
	);

	// Result register: control bit reset, payload loads on accept only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s1 <= 1'b0;
		end else if (accept) begin
			rsp_valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_s1 <= seq_res;
		end
	end

	assign rsp.valid       = rsp_valid_s1;
	assign rsp.clock_pulse = rsp_s1.clock_pulse;
	assign rsp.swdio_out   = rsp_s1.swdio_out;
	assign rsp.swdio_oe    = rsp_s1.swdio_oe;
	assign rsp.done_res    = rsp_s1.done_res;
	assign rsp.status      = rsp_s1.status;
	assign rsp.read_data   = rsp_s1.read_data;
	assign rsp.last_ack    = rsp_s1.last_ack;
	assign rsp.busy_res    = rsp_s1.busy_res;

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_s1)
		else $error("accepted command produced no result");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_s1 && !rsp.ready) |-> !cmd.ready)
		else $error("command accepted while result register is stalled");

	a_status_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_s1 && rsp_s1.status) |-> rsp_s1.done_res)
		else $error("failure status without done");

endmodule

FILE: verif/swdh_pin_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD host pin checker
// Watches the command, result and retry_limit ports, keeps its own copy of
// the pin sequencer and compares every result transfer in order.
// ----------------------------------------------------------------------------
module swdh_pin_checker
	import swdh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	swdh_cmd_if                 cmd,
	swdh_rsp_if                 rsp,
	input  logic                cfg_we,
	input  logic [RETRY_W-1:0]  cfg_wdata,
	output int unsigned         errors,
	output int unsigned         outstanding,
	output phase_t              seq_phase,
	output logic [BITCNT_W-1:0] seq_bits,
	output logic                seq_parity,
	output int unsigned         n_xfer_ok,
	output int unsigned         n_xfer_fail,
	output int unsigned         n_line_resets,
	output int unsigned         n_recoveries
);

	logic [RETRY_W-1:0] retry_lim;
	logic               drives;
	logic [RETRY_W-1:0] tries;
	logic [3:0]         req;
	logic [WORD_W-1:0]  shifter;
	logic [WORD_W-1:0]  last_read;
	logic [ACK_W-1:0]   ack;

	swdh_result_t pin_expect_q[$];

	// Bit counter shared by all phases; true when lim bits have gone out.
	function automatic logic bump(input logic [LIMIT_W-1:0] lim);
		logic [LIMIT_W-1:0] n;
		n = {1'b0, seq_bits} + 1'b1;
		if (n >= lim) begin
			seq_bits = '0;
			return 1'b1;
		end
		seq_bits = n[BITCNT_W-1:0];
		return 1'b0;
	endfunction

	task automatic sequence_tick(
		input  logic [FUNC_W-1:0] f,
		input  logic              ap,
		input  logic              rnw,
		input  logic [ADDR_W-1:0] a,
		input  logic [WORD_W-1:0] wd,
		input  logic              din,
		output swdh_result_t      r
	);
		logic       clkp, dout, done, stat, need, turn;
		logic [7:0] req_byte;
		clkp = 1'b0;
		dout = 1'b0;
		done = 1'b0;
		stat = 1'b0;
		turn = 1'b0;
		req_byte = {1'b1, 1'b0, ^req, req[3:2], req[1], req[0], 1'b1};
		if (f == FUNC_START && seq_phase == PH_IDLE) begin
			req = {a, rnw, ap};
			shifter = wd;
			tries = '0;
			seq_bits = '0;
			seq_phase = PH_REQ;
		end else if (f == FUNC_LRST && seq_phase == PH_IDLE) begin
			drives = 1'b0;
			seq_bits = '0;
			seq_phase = PH_RST_HI1;
		end else if (f == FUNC_TICK && seq_phase != PH_IDLE) begin
			need = !(seq_phase inside {PH_ACK, PH_RDATA, PH_RPAR});
			clkp = 1'b1;
			if (need != drives) begin
				// turnaround: clock with the line released, no protocol bit
				drives = need;
				turn = 1'b1;
			end else begin
				case (seq_phase)
					PH_RST_HI1: begin
						dout = 1'b1;
						if (bump(RESET_ONES)) seq_phase = PH_RST_KEY;
					end
					PH_RST_KEY: begin
						dout = SWITCH_KEY[seq_bits[3:0]];
						if (bump(SWITCH_KEY_BITS)) seq_phase = PH_RST_HI2;
					end
					PH_RST_HI2: begin
						dout = 1'b1;
						if (bump(RESET_ONES)) seq_phase = PH_RST_LO;
					end
					PH_RST_LO: begin
						if (bump(RESET_ZEROS)) begin
							seq_phase = PH_IDLE;
							done = 1'b1;
							n_line_resets++;
						end
					end
					PH_REQ: begin
						dout = req_byte[seq_bits[2:0]];
						if (bump(REQ_BITS)) begin
							seq_phase = PH_ACK;
							ack = '0;
						end
					end
					PH_ACK: begin
						ack = ack | (ACK_W'(din) << seq_bits[1:0]);
						if (bump(ACK_BITS)) begin
							seq_parity = 1'b0;
							if (ack != ACK_OK) begin
								seq_phase = PH_RECOVER;
								n_recoveries++;
							end else if (req[1]) begin
								shifter = '0;
								seq_phase = PH_RDATA;
							end else begin
								seq_phase = PH_WDATA;
							end
						end
					end
					PH_RDATA: begin
						shifter = shifter | (WORD_W'(din) << seq_bits[4:0]);
						seq_parity = seq_parity ^ din;
						if (bump(DATA_BITS)) seq_phase = PH_RPAR;
					end
					PH_RPAR: begin
						seq_bits = '0;
						if (din == seq_parity) begin
							last_read = shifter;
							seq_phase = PH_TRAIL;
						end else begin
							seq_phase = PH_RECOVER;
							n_recoveries++;
						end
					end
					PH_WDATA: begin
						dout = shifter[seq_bits[4:0]];
						seq_parity = seq_parity ^ dout;
						if (bump(DATA_BITS)) seq_phase = PH_WPAR;
					end
					PH_WPAR: begin
						dout = seq_parity;
						seq_bits = '0;
						seq_phase = PH_TRAIL;
					end
					PH_TRAIL: begin
						seq_bits = '0;
						seq_phase = PH_IDLE;
						done = 1'b1;
						n_xfer_ok++;
					end
					PH_RECOVER: begin
						if (bump(RECOVERY_IDLE_BITS)) begin
							tries = tries + 1'b1;
							// a limit of zero gives up after one attempt, like one
							if (tries >= retry_lim) begin
								seq_phase = PH_IDLE;
								done = 1'b1;
								stat = 1'b1;
								n_xfer_fail++;
							end else begin
								seq_phase = PH_REQ;
							end
						end
					end
					default: begin
						seq_phase = PH_IDLE;
						seq_bits = '0;
						clkp = 1'b0;
					end
				endcase
			end
		end
		r.clock_pulse = clkp;
		r.swdio_oe    = turn ? 1'b0 : drives;
		r.swdio_out   = r.swdio_oe ? dout : 1'b0;
		r.done_res    = done;
		r.status      = stat;
		r.read_data   = last_read;
		r.last_ack    = ack;
		r.busy_res    = (seq_phase != PH_IDLE);
	endtask

	task automatic note_error(input string what, input swdh_result_t want,
			input swdh_result_t got);
		errors++;
		if (errors <= 10)
			$display("%0t result error (%s): clk %b/%b out %b/%b oe %b/%b done %b/%b",
				$realtime, what, want.clock_pulse, got.clock_pulse, want.swdio_out,
				got.swdio_out, want.swdio_oe, got.swdio_oe, want.done_res, got.done_res,
				"  status %b/%b data %h/%h ack %b/%b busy %b/%b  (expected/actual)",
				want.status, got.status, want.read_data, got.read_data,
				want.last_ack, got.last_ack, want.busy_res, got.busy_res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		swdh_result_t want, got;
		if (!arst_n) begin
			retry_lim = RETRY_LIMIT_RST;
			seq_phase = PH_IDLE;
			seq_bits = '0;
			seq_parity = 1'b0;
			shifter = '0;
			drives = 1'b0;
			tries = '0;
			req = '0;
			last_read = '0;
			ack = '0;
			errors = 0;
			n_xfer_ok = 0;
			n_xfer_fail = 0;
			n_line_resets = 0;
			n_recoveries = 0;
			pin_expect_q.delete();
		end else begin
			if (cfg_we)
				retry_lim = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				got = {rsp.clock_pulse, rsp.swdio_out, rsp.swdio_oe, rsp.done_res,
					rsp.status, rsp.read_data, rsp.last_ack, rsp.busy_res};
				if (pin_expect_q.size() == 0) begin
					note_error("nothing outstanding", '0, got);
				end else begin
					want = pin_expect_q.pop_front();
					if (got !== want)
						note_error("field differs", want, got);
				end
			end
			if (cmd.valid && cmd.ready) begin
				sequence_tick(cmd.func, cmd.ap_not_dp, cmd.read_not_write, cmd.reg_addr,
					cmd.write_data, cmd.swdio_in, want);
				pin_expect_q.push_back(want);
			end
		end
		outstanding = pin_expect_q.size();
	end

endmodule

FILE: verif/swd_host_transfer_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SWD host transfer engine testbench
// Drives commands and ticks into the engine, with random gaps on both channels
// and a long result hold-off, and lets the pin checker verify every result.
// ----------------------------------------------------------------------------
module swd_host_transfer_engine_core_tb;
	import swdh_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned PHASE_ITEMS  = 130;     // five random phases, ~650 items
	localparam int unsigned HOLD_CYCLES  = 120;     // long result hold-off

	// How the "target" answers on SWDIO during a transfer.
	typedef enum logic [1:0] {
		LINE_CLEAN,     // OK ack, good read parity
		LINE_NOISY,     // ack and parity random
		LINE_BAD_ACK,   // always WAIT
		LINE_BAD_PAR    // OK ack, read parity flipped
	} line_mode_e;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [RETRY_W-1:0] cfg_wdata;

	swdh_cmd_if cmd_ch ();
	swdh_rsp_if rsp_ch ();

	int unsigned errors;
	int unsigned outstanding;
	phase_t      seq_phase;
	logic [BITCNT_W-1:0] seq_bits;
	logic        seq_parity;
	int unsigned n_xfer_ok, n_xfer_fail, n_line_resets, n_recoveries;

	int unsigned        cycles;
	int unsigned        items_sent;
	int unsigned        rsp_taken;
	int unsigned        holds_done;
	int unsigned        settings_used;
	logic [RETRY_W-1:0] limit_now;

	swd_host_transfer_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	swdh_pin_checker pin_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_ch),
		.rsp           (rsp_ch),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.outstanding   (outstanding),
		.seq_phase     (seq_phase),
		.seq_bits      (seq_bits),
		.seq_parity    (seq_parity),
		.n_xfer_ok     (n_xfer_ok),
		.n_xfer_fail   (n_xfer_fail),
		.n_line_resets (n_line_resets),
		.n_recoveries  (n_recoveries)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("swd_host_transfer_engine_core: mismatch");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			rsp_taken++;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Word with a bias toward the all-zero and all-one extremes.
	function automatic logic [WORD_W-1:0] pick_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom();
	endfunction

	// SWDIO level for the next tick. The checker's sequencer state is current
	// here: every earlier item has been transferred by this falling edge.
	function automatic logic line_level(input line_mode_e mode, input logic [WORD_W-1:0] word);
		logic coin;
		coin = 1'($urandom_range(0, 1));
		case (seq_phase)
			PH_ACK: begin
				if (mode == LINE_NOISY)
					return coin;
				if (mode == LINE_BAD_ACK)
					return seq_bits == 1;    // 3'b010, WAIT
				return seq_bits == 0;        // 3'b001, OK
			end
			PH_RDATA:
				return word[seq_bits[4:0]];
			PH_RPAR: begin
				if (mode == LINE_NOISY)
					return coin;
				return (mode == LINE_BAD_PAR) ? ~seq_parity : seq_parity;
			end
			default:
				return coin;
		endcase
	endfunction

	// One command transfer. Called at a falling edge; returns at the falling
	// edge after the transfer with valid still high, so the next call either
	// raises it for a fresh item or drops it for a gap, never both in a step.
	task automatic send(
		input logic [FUNC_W-1:0] f,
		input logic              ap,
		input logic              rnw,
		input logic [ADDR_W-1:0] a,
		input logic [WORD_W-1:0] wd,
		input logic              din,
		input bit                steady
	);
		int unsigned gap;
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid          <= 1'b1;
		cmd_ch.func           <= f;
		cmd_ch.ap_not_dp      <= ap;
		cmd_ch.read_not_write <= rnw;
		cmd_ch.reg_addr       <= a;
		cmd_ch.write_data     <= wd;
		cmd_ch.swdio_in       <= din;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Item with every field random, func 3 included.
	task automatic send_stray(input bit steady);
		send(FUNC_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), ADDR_W'($urandom_range(0, 3)), $urandom(),
			1'($urandom_range(0, 1)), steady);
	endtask

	// Issue one command, then tick until the sequencer is back to idle. Tick
	// items carry random junk in the unused fields. With noisy set, stray
	// commands (starts and resets while busy, func 3, odd ticks) are mixed in.
	task automatic run_command(
		input logic [FUNC_W-1:0] f,
		input logic              ap,
		input logic              rnw,
		input logic [ADDR_W-1:0] a,
		input logic [WORD_W-1:0] wd,
		input logic [WORD_W-1:0] word,
		input line_mode_e        mode,
		input bit                noisy
	);
		bit steady;
		steady = ($urandom_range(0, 3) == 0);
		send(f, ap, rnw, a, wd, 1'($urandom_range(0, 1)), steady);
		while (seq_phase != PH_IDLE) begin
			if (noisy && $urandom_range(0, 39) == 0)
				send_stray(steady);
			else
				send(FUNC_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					ADDR_W'($urandom_range(0, 3)), $urandom(), line_level(mode, word),
					steady);
		end
	endtask

	task automatic random_transfer();
		int unsigned r;
		line_mode_e  mode;
		r = $urandom_range(0, 99);
		// hard failures only where the retry limit keeps them short
		if (limit_now <= 3)
			mode = (r < 15) ? LINE_BAD_ACK : (r < 30) ? LINE_BAD_PAR :
				(r < 55) ? LINE_NOISY : LINE_CLEAN;
		else
			mode = (r < 10) ? LINE_NOISY : LINE_CLEAN;
		run_command(FUNC_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			ADDR_W'($urandom_range(0, 3)), pick_word(), pick_word(), mode,
			$urandom_range(0, 9) < 3);
	endtask

	// Drop valid and let every result come back (before a retry_limit write or
	// the drain). Each command above ends with the sequencer idle, so it is quiet.
	task automatic quiesce();
		cmd_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_retry_limit(input logic [RETRY_W-1:0] v);
		quiesce();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		limit_now = v;
		settings_used++;
	endtask

	// Result side: random ready gaps, quiet stretches, and a long hold-off
	// every few hundred results so the engine fills and stalls its input.
	initial begin : result_sink
		int unsigned gap;
		int unsigned next_hold;
		rsp_ch.ready = 1'b0;
		next_hold = 150;
		holds_done = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rsp_taken >= next_hold) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
				next_hold = rsp_taken + 400;
			end else begin
				gap = ((rsp_taken / 64) % 4 == 3) ? 0 : pick_gap();
				if (gap != 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				rsp_ch.ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [RETRY_W-1:0] plan [5];
		int unsigned        start_items;
		int unsigned        r;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		cmd_ch.valid          = 1'b0;
		cmd_ch.func           = FUNC_TICK;
		cmd_ch.ap_not_dp      = 1'b0;
		cmd_ch.read_not_write = 1'b0;
		cmd_ch.reg_addr       = '0;
		cmd_ch.write_data     = '0;
		cmd_ch.swdio_in       = 1'b0;
		cycles                = 0;
		items_sent            = 0;
		rsp_taken             = 0;
		settings_used         = 1;
		limit_now             = RETRY_LIMIT_RST;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ---- directed part, retry_limit at its reset value ----
		// A tick while idle and the unused func code give no clock.
		send(FUNC_TICK, 1'b1, 1'b1, 2'd3, '1, 1'b1, 1'b0);
		send(2'd3, 1'b1, 1'b1, 2'd3, '1, 1'b1, 1'b0);
		// Line reset; the line starts released, so its first tick is a
		// turnaround. Start, line reset and func 3 while busy are dropped.
		send(FUNC_LRST, 1'b0, 1'b0, 2'd0, '0, 1'b0, 1'b0);
		send(FUNC_START, 1'b1, 1'b1, 2'd3, '1, 1'b1, 1'b0);
		send(FUNC_LRST, 1'b0, 1'b0, 2'd0, '0, 1'b0, 1'b0);
		send(2'd3, 1'b0, 1'b0, 2'd0, '0, 1'b0, 1'b0);
		run_command(FUNC_TICK, 1'b0, 1'b0, 2'd0, '0, '0, LINE_CLEAN, 1'b0);
		// Writes and reads at the field extremes, clean target.
		run_command(FUNC_START, 1'b1, 1'b0, 2'd3, '1, '0, LINE_CLEAN, 1'b0);
		run_command(FUNC_START, 1'b0, 1'b0, 2'd0, '0, '0, LINE_CLEAN, 1'b0);
		run_command(FUNC_START, 1'b0, 1'b1, 2'd0, '0, '0, LINE_CLEAN, 1'b0);
		run_command(FUNC_START, 1'b1, 1'b1, 2'd3, '0, '1, LINE_CLEAN, 1'b0);
		run_command(FUNC_START, 1'b1, 1'b1, 2'd1, '0, 32'h5AA5_C33C, LINE_CLEAN, 1'b0);
		// With two attempts: read parity error, WAIT ack; both give up.
		set_retry_limit(4'd2);
		run_command(FUNC_START, 1'b0, 1'b1, 2'd2, '0, 32'h8000_0001, LINE_BAD_PAR, 1'b0);
		run_command(FUNC_START, 1'b1, 1'b0, 2'd1, '1, '0, LINE_BAD_ACK, 1'b0);

		// ---- random phases over several retry limits, zero and 15 included ----
		plan[0] = 4'd1;
		plan[1] = 4'd0;
		plan[2] = 4'd3;
		plan[3] = RETRY_W'($urandom_range(4, 14));
		plan[4] = 4'd15;
		foreach (plan[p]) begin
			set_retry_limit(plan[p]);
			start_items = items_sent;
			while (items_sent - start_items < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 78) begin
					random_transfer();
				end else if (r < 82) begin
					run_command(FUNC_LRST, 1'b0, 1'b0, 2'd0, '0, '0, LINE_CLEAN, 1'b1);
				end else begin
					// stray items, then tick whatever they started to its end
					repeat ($urandom_range(1, 4)) send_stray(1'b0);
					run_command(FUNC_TICK, 1'b0, 1'b0, 2'd0, '0, pick_word(),
						LINE_CLEAN, 1'b0);
				end
			end
		end

		// Drain: every expected result back, then an idle margin before the report.
		quiesce();
		repeat (6) @(negedge clk);
		$display("covered %0d items under %0d retry limits, %0d transfers done,",
			items_sent, settings_used, n_xfer_ok);
		$display("  %0d given up, %0d recovery passes, %0d line resets, %0d long holds",
			n_xfer_fail, n_recoveries, n_line_resets, holds_done);
		if (errors == 0)
			$display("swd_host_transfer_engine_core: match");
		else
			$display("swd_host_transfer_engine_core: mismatch");
		$finish;
	end

endmodule
